// ===== src/tcb_pkg.sv =====
// tcb_pkg: shared types and constants for the text console buffer
// holds the request, response and internal command types and the sequencer states
// no dependencies
package tcb_pkg;

    // character codes
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // command field codes
    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // input transaction
    typedef struct packed {
        logic       command;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_column;
    } request_t;

    // output transaction
    typedef struct packed {
        logic [7:0] cell_char;
        logic       row_out_of_range;
        logic [6:0] cursor_column;
        logic [4:0] cursor_line;
    } response_t;

    // classified operation
    typedef enum logic [1:0] {
        OP_PUT,
        OP_NEWLINE,
        OP_READ
    } op_t;

    // command queue entry between front and back
    typedef struct packed {
        op_t        op;
        logic [7:0] char_code;
        logic [4:0] row;
        logic [6:0] col;
        logic       row_bad;
        logic       col_bad;
    } entry_t;

    // back-end sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_BLANK,
        ST_ACCESS,
        ST_FINISH
    } state_t;

endpackage

// ===== src/tcb_queue.sv =====
// tcb_queue: small synchronous fifo used between the console stages
// generic over the item type; no package dependencies
module tcb_queue #(
    parameter type item_t = logic,
    parameter int  DEPTH  = 2
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output item_t head,
    output logic  empty
);
    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    item_t          slots[DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    // handshake qualification
    assign full    = (count_reg == NW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign head    = slots[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + NW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== src/tcb_front.sv =====
// tcb_front: accepts console requests and classifies them into queue entries
// depends on tcb_pkg for request and entry types
module tcb_front #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 24
) (
    input  logic              push,
    output logic              full,
    input  tcb_pkg::request_t request,
    input  logic              q_full,
    output logic              q_push,
    output tcb_pkg::entry_t   entry
);
    import tcb_pkg::*;

    logic is_read;

    // pass the queue state back as input backpressure
    assign full   = q_full;
    assign q_push = push & ~q_full;

    // decode the command and range-check read coordinates
    always_comb
    begin
        is_read         = (request.command == CMD_READ);
        entry.char_code = request.char_code;
        entry.row       = request.read_row;
        entry.col       = request.read_column;
        entry.row_bad   = is_read && (int'(request.read_row) >= ROWS);
        entry.col_bad   = is_read && (int'(request.read_column) >= COLUMNS);
        if (is_read)
        begin
            entry.op = OP_READ;
        end
        else if (request.char_code == CH_NEWLINE)
        begin
            entry.op = OP_NEWLINE;
        end
        else
        begin
            entry.op = OP_PUT;
        end
    end

endmodule

// ===== src/tcb_back.sv =====
// tcb_back: cursor, scroll offset and screen memory sequencer
// depends on tcb_pkg for entry, response and state types
module tcb_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tcb_pkg::entry_t    q_head,
    input  logic               q_empty,
    output logic               q_pop,
    output logic               res_push,
    output tcb_pkg::response_t res_item,
    input  logic               res_full
);
    import tcb_pkg::*;

    localparam int DEPTH = ROWS * COLUMNS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(ROWS);
    localparam int SW    = RW + 1;
    localparam int CIW   = $clog2(COLUMNS);
    localparam int CW    = $clog2(COLUMNS + 1);
    localparam logic [AW-1:0] COL_STEP = AW'(COLUMNS);
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

    // screen memory
    logic [7:0]    mem[DEPTH];
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata;
    logic [7:0]    rdata_reg;

    // sequencer and cursor state
    state_t         state_reg, state_next;
    state_t         ret_reg, ret_next;
    logic [CW-1:0]  cur_col_reg, cur_col_next;
    logic [RW-1:0]  cur_row_reg, cur_row_next;
    logic [RW-1:0]  top_reg, top_next;
    logic [AW-1:0]  cnt_reg, cnt_next;

    // current item
    op_t            op_reg, op_next;
    logic [7:0]     char_reg, char_next;
    logic [RW-1:0]  row_reg, row_next;
    logic [6:0]     rcol_reg, rcol_next;
    logic           row_bad_reg, row_bad_next;
    logic           col_bad_reg, col_bad_next;
    logic [RW-1:0]  line_reg, line_next;
    logic [CIW-1:0] col_reg, col_next;
    logic           hit_reg, hit_next;

    logic           take;
    logic           is_last;
    logic [RW-1:0]  top_inc;
    logic [RW-1:0]  row_inc;
    logic [AW-1:0]  line_base;
    logic [CW-1:0]  col_inc;

    // screen line to physical line through the rotating top offset
    function automatic logic [RW-1:0] phys_line(input logic [RW-1:0] line,
                                                input logic [RW-1:0] top);
        logic [SW-1:0] sum;
        sum = {1'b0, line} + {1'b0, top};
        if (sum >= SW'(ROWS))
        begin
            sum = sum - SW'(ROWS);
        end
        return sum[RW-1:0];
    endfunction

    // shared address and cursor arithmetic
    assign is_last   = (cur_row_reg == LAST_ROW);
    assign top_inc   = (top_reg == LAST_ROW) ? '0 : top_reg + RW'(1);
    assign row_inc   = cur_row_reg + RW'(1);
    assign line_base = AW'(line_reg) * COL_STEP;
    assign col_inc   = CW'(col_reg) + CW'(1);

    // next state and outputs
    always_comb
    begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        top_next     = top_reg;
        cnt_next     = cnt_reg;
        op_next      = op_reg;
        char_next    = char_reg;
        row_next     = row_reg;
        rcol_next    = rcol_reg;
        row_bad_next = row_bad_reg;
        col_bad_next = col_bad_reg;
        line_next    = line_reg;
        col_next     = col_reg;
        hit_next     = hit_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_waddr    = line_base + AW'(col_reg);
        mem_raddr    = line_base + AW'(col_reg);
        mem_wdata    = char_reg;
        take         = 1'b0;
        q_pop        = 1'b0;
        res_push     = 1'b0;
        res_item.cell_char        = '0;
        res_item.row_out_of_range = row_bad_reg;
        res_item.cursor_column    = 7'(cur_col_reg);
        res_item.cursor_line      = 5'(cur_row_reg);

        case (state_reg)
            // fill the whole screen with spaces after reset
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = CH_SPACE;
                cnt_next  = cnt_reg + AW'(1);
                if (cnt_reg == AW'(DEPTH - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                take = 1'b1;
            end

            // cursor movement and target line selection
            ST_EXEC:
            begin
                case (op_reg)
                    OP_READ:
                    begin
                        hit_next = 1'b0;
                        if (row_bad_reg || col_bad_reg)
                        begin
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            line_next  = phys_line(row_reg, top_reg);
                            col_next   = CIW'(rcol_reg);
                            state_next = ST_ACCESS;
                        end
                    end
                    OP_NEWLINE:
                    begin
                        hit_next     = 1'b0;
                        cur_col_next = '0;
                        if (is_last)
                        begin
                            top_next   = top_inc;
                            line_next  = top_reg;
                            cnt_next   = '0;
                            ret_next   = ST_FINISH;
                            state_next = ST_BLANK;
                        end
                        else
                        begin
                            cur_row_next = row_inc;
                            state_next   = ST_FINISH;
                        end
                    end
                    default:
                    begin
                        if (cur_col_reg == CW'(COLUMNS))
                        begin
                            // pending wrap before the store
                            cur_col_next = '0;
                            col_next     = '0;
                            if (is_last)
                            begin
                                top_next   = top_inc;
                                line_next  = top_reg;
                                cnt_next   = '0;
                                ret_next   = ST_ACCESS;
                                state_next = ST_BLANK;
                            end
                            else
                            begin
                                cur_row_next = row_inc;
                                line_next    = phys_line(row_inc, top_reg);
                                state_next   = ST_ACCESS;
                            end
                        end
                        else
                        begin
                            col_next   = CIW'(cur_col_reg);
                            line_next  = phys_line(cur_row_reg, top_reg);
                            state_next = ST_ACCESS;
                        end
                    end
                endcase
            end

            // blank the freed line after a scroll
            ST_BLANK:
            begin
                mem_we    = 1'b1;
                mem_waddr = line_base + cnt_reg;
                mem_wdata = CH_SPACE;
                cnt_next  = cnt_reg + AW'(1);
                if (cnt_reg == AW'(COLUMNS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ret_reg;
                end
            end

            // one memory access: read a cell or store a character
            ST_ACCESS:
            begin
                if (op_reg == OP_READ)
                begin
                    mem_re     = 1'b1;
                    hit_next   = 1'b1;
                    state_next = ST_FINISH;
                end
                else if (!res_full)
                begin
                    mem_we                 = 1'b1;
                    cur_col_next           = col_inc;
                    res_push               = 1'b1;
                    res_item.cursor_column = 7'(col_inc);
                    take                   = 1'b1;
                end
            end

            ST_FINISH:
            begin
                if (!res_full)
                begin
                    res_push           = 1'b1;
                    res_item.cell_char = hit_reg ? rdata_reg : '0;
                    take               = 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // load the next command when the current one is done
        if (take)
        begin
            if (!q_empty)
            begin
                q_pop        = 1'b1;
                op_next      = q_head.op;
                char_next    = q_head.char_code;
                row_next     = RW'(q_head.row);
                rcol_next    = q_head.col;
                row_bad_next = q_head.row_bad;
                col_bad_next = q_head.col_bad;
                state_next   = ST_EXEC;
            end
            else
            begin
                state_next = ST_IDLE;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            ret_reg     <= ST_FINISH;
            cur_col_reg <= '0;
            cur_row_reg <= '0;
            top_reg     <= '0;
            cnt_reg     <= '0;
            hit_reg     <= 1'b0;
            op_reg      <= OP_PUT;
            row_bad_reg <= 1'b0;
            col_bad_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
            top_reg     <= top_next;
            cnt_reg     <= cnt_next;
            hit_reg     <= hit_next;
            op_reg      <= op_next;
            row_bad_reg <= row_bad_next;
            col_bad_reg <= col_bad_next;
        end
    end

    // item payload registers
    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        row_reg  <= row_next;
        rcol_reg <= rcol_next;
        line_reg <= line_next;
        col_reg  <= col_next;
    end

    // screen memory ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // no command is taken during the clearing pass
    a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !q_pop)
        else $error("command taken during screen clear");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("command queue popped while empty");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into full queue");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_row_reg <= LAST_ROW) && (cur_col_reg <= CW'(COLUMNS))
        && (top_reg <= LAST_ROW))
        else $error("cursor or top offset out of range");

    // a scroll advances the top offset by exactly one line
    a_scroll_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) && (top_next != top_reg) |=> (top_reg == $past(top_inc)))
        else $error("top offset moved by more than one line");

endmodule

// ===== src/text_console_buffer.sv =====
// text_console_buffer: a put character passes back-end states EXEC and ACCESS; a newline EXEC and
// FINISH; a cell read EXEC, ACCESS (registered memory read) and FINISH; each queue adds a register.
// a wrap or newline on the last row scrolls and blanks the new line in state BLANK. throughput is
// set by the screen memory sequencer, which takes a new command only after the last one is done.
// after reset the screen is cleared to spaces before commands run;
// cursor and top offset reset to zero. depends on tcb_pkg, tcb_front, tcb_queue, tcb_back
module text_console_buffer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  tcb_pkg::request_t  request,
    output logic               empty,
    input  logic               pop,
    output tcb_pkg::response_t response
);
    import tcb_pkg::*;

    entry_t    fe_entry;
    entry_t    q_head;
    logic      fe_push;
    logic      q_full, q_empty, q_pop;
    response_t res_item;
    logic      res_push, res_full;

    // request classification
    tcb_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .push    (push),
        .full    (full),
        .request (request),
        .q_full  (q_full),
        .q_push  (fe_push),
        .entry   (fe_entry)
    );

    // command queue between front and back
    tcb_queue #(
        .item_t (entry_t),
        .DEPTH  (2)
    ) u_cmd_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fe_push),
        .push_item (fe_entry),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    // screen store and cursor sequencer
    tcb_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_head   (q_head),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .res_push (res_push),
        .res_item (res_item),
        .res_full (res_full)
    );

    // result queue toward the consumer
    tcb_queue #(
        .item_t (response_t),
        .DEPTH  (2)
    ) u_res_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_item (res_item),
        .full      (res_full),
        .pop       (pop),
        .head      (response),
        .empty     (empty)
    );

endmodule
